>>> rtl/dfi_pkg.sv
package dfi_pkg;

   localparam int ORDER = 2;

   localparam int SMP_W     = 16;
   localparam int COEF_W    = 24;
   localparam int PROD_W    = SMP_W + COEF_W;
   localparam int ACC_W     = 48;
   localparam int FRAC_BITS = 20;
   localparam int RND_W     = ACC_W - FRAC_BITS;

   localparam int NUM_B   = 3;
   localparam int NUM_A   = 2;
   localparam int B_IDX_W = 2;
   localparam int A_IDX_W = 1;

   localparam int HIST_DEPTH = 2 * ORDER;
   localparam int HIST_AW    = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

   localparam int STEP_LAST = 2 * ORDER + 2;
   localparam int STEP_W    = $clog2(STEP_LAST + 1);

   localparam int CSR_AW = 3;
   localparam int CSR_DW = COEF_W;

   localparam logic [CSR_AW-1:0] REG_FIR_MODE = 3'd0;
   localparam logic [CSR_AW-1:0] REG_B0_COEF  = 3'd1;
   localparam logic [CSR_AW-1:0] REG_B1_COEF  = 3'd2;
   localparam logic [CSR_AW-1:0] REG_B2_COEF  = 3'd3;
   localparam logic [CSR_AW-1:0] REG_A1_COEF  = 3'd4;
   localparam logic [CSR_AW-1:0] REG_A2_COEF  = 3'd5;

   localparam logic OP_FILTER = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic signed [COEF_W-1:0] B0_RESET = 24'sd1048576;

   typedef struct packed {
      logic                    en;
      logic [HIST_AW-1:0]      addr;
      logic signed [SMP_W-1:0] data;
   } hist_wr_type;

   typedef struct packed {
      logic acc_clear;
      logic mul_en;
      logic neg;
      logic zero;
      logic acc_en;
   } mac_ctrl_type;

endpackage

>>> rtl/dfi_hist_mem.sv
module dfi_hist_mem (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic [dfi_pkg::HIST_AW-1:0]      rd_addr,
   input  dfi_pkg::hist_wr_type             wr,
   output logic signed [dfi_pkg::SMP_W-1:0] rd_data
);

   logic signed [dfi_pkg::SMP_W-1:0] mem [0:dfi_pkg::HIST_DEPTH-1];
   logic [dfi_pkg::HIST_DEPTH-1:0]   vld_ff;
   logic [dfi_pkg::HIST_DEPTH-1:0]   vld_in;
   logic signed [dfi_pkg::SMP_W-1:0] rd_raw_ff;
   logic                             rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (clear) begin
         vld_in = '0;
      end else if (wr.en) begin
         vld_in[wr.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff    <= vld_in;
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

>>> rtl/dfi_mac.sv
module dfi_mac (
   input  logic                              clock,
   input  dfi_pkg::mac_ctrl_type             ctrl,
   input  logic signed [dfi_pkg::COEF_W-1:0] coef,
   input  logic signed [dfi_pkg::SMP_W-1:0]  opnd,
   output logic signed [dfi_pkg::SMP_W-1:0]  y,
   output logic                              sat
);

   logic signed [dfi_pkg::PROD_W-1:0] prod_ff;
   logic signed [dfi_pkg::PROD_W-1:0] prod_in;
   logic                              neg_ff;
   logic                              zero_ff;
   logic signed [dfi_pkg::ACC_W-1:0]  acc_ff;
   logic signed [dfi_pkg::ACC_W-1:0]  acc_in;
   logic signed [dfi_pkg::ACC_W-1:0]  term;
   logic signed [dfi_pkg::ACC_W-1:0]  biased;
   logic signed [dfi_pkg::RND_W-1:0]  rnd;
   logic [dfi_pkg::RND_W-dfi_pkg::SMP_W:0] top_bits;

   assign prod_in = dfi_pkg::PROD_W'(coef) * dfi_pkg::PROD_W'(opnd);

   always_comb begin
      term = dfi_pkg::ACC_W'(prod_ff);
      if (zero_ff) begin
         term = '0;
      end else if (neg_ff) begin
         term = -dfi_pkg::ACC_W'(prod_ff);
      end
      acc_in = acc_ff;
      if (ctrl.acc_clear) begin
         acc_in = '0;
      end else if (ctrl.acc_en) begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
         neg_ff  <= ctrl.neg;
         zero_ff <= ctrl.zero;
      end
      acc_ff <= acc_in;
   end

   // Adding half an LSB and taking the upper bits rounds to nearest, with ties toward positive infinity.
   assign biased   = acc_ff + (dfi_pkg::ACC_W'(1) <<< (dfi_pkg::FRAC_BITS - 1));
   assign rnd      = biased[dfi_pkg::ACC_W-1:dfi_pkg::FRAC_BITS];
   assign top_bits = rnd[dfi_pkg::RND_W-1:dfi_pkg::SMP_W-1];
   assign sat      = (top_bits != '0) && (top_bits != '1);

   always_comb begin
      y = rnd[dfi_pkg::SMP_W-1:0];
      if (sat) begin
         y = rnd[dfi_pkg::RND_W-1] ? {1'b1, {(dfi_pkg::SMP_W-1){1'b0}}}
                                   : {1'b0, {(dfi_pkg::SMP_W-1){1'b1}}};
      end
   end

endmodule

>>> rtl/iir_fir_direct_form_filter_core.sv
// Direct form I biquad filter with Q3.20 coefficients and Q0.15 samples. A new
// sample is accepted only after the previous filter transfer has finished,
// since one shared multiply-accumulate unit visits every tap in turn
// while the input and output histories are read from and shifted within a single
// one-port-read history memory. A clear transfer gives no result. Each result is
// rounded, saturated and flagged in rsp_tuser, and the next sample is taken while
// a finished result still waits in the output register.
module iir_fir_direct_form_filter_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [dfi_pkg::SMP_W-1:0]          req_tdata,  // [15:0] sample
   input  logic                               req_tuser,  // [0] op
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [dfi_pkg::SMP_W-1:0]          rsp_tdata,  // [15:0] filtered
   output logic                               rsp_tuser,  // [0] saturated
   input  logic                               csr_we,
   input  logic [dfi_pkg::CSR_AW-1:0]         csr_addr,
   input  logic [dfi_pkg::CSR_DW-1:0]         csr_wdata
);

   logic                              fir_mode_ff;
   logic signed [dfi_pkg::COEF_W-1:0] b_ff [0:dfi_pkg::NUM_B-1];
   logic signed [dfi_pkg::COEF_W-1:0] a_ff [0:dfi_pkg::NUM_A-1];

   logic                              busy_ff;
   logic                              busy_in;
   logic [dfi_pkg::STEP_W-1:0]        step_ff;
   logic [dfi_pkg::STEP_W-1:0]        step_in;
   logic signed [dfi_pkg::SMP_W-1:0]  x_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [dfi_pkg::SMP_W-1:0]         rsp_data_ff;
   logic                              rsp_sat_ff;

   logic                              accept;
   logic                              hist_clear;
   logic                              finish;
   logic                              fb_tap;
   logic [dfi_pkg::STEP_W-1:0]        a_full;
   logic signed [dfi_pkg::COEF_W-1:0] coef;
   logic signed [dfi_pkg::SMP_W-1:0]  opnd;
   logic signed [dfi_pkg::SMP_W-1:0]  hist_rd;
   logic signed [dfi_pkg::SMP_W-1:0]  y;
   logic                              sat;
   dfi_pkg::hist_wr_type              hist_wr;
   dfi_pkg::mac_ctrl_type             mac_ctrl;

   always_ff @(posedge clock) begin
      if (reset) begin
         fir_mode_ff <= 1'b0;
         b_ff[0]     <= dfi_pkg::B0_RESET;
         b_ff[1]     <= '0;
         b_ff[2]     <= '0;
         a_ff[0]     <= '0;
         a_ff[1]     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            dfi_pkg::REG_FIR_MODE: fir_mode_ff <= csr_wdata[0];
            dfi_pkg::REG_B0_COEF:  b_ff[0]     <= csr_wdata;
            dfi_pkg::REG_B1_COEF:  b_ff[1]     <= csr_wdata;
            dfi_pkg::REG_B2_COEF:  b_ff[2]     <= csr_wdata;
            dfi_pkg::REG_A1_COEF:  a_ff[0]     <= csr_wdata;
            dfi_pkg::REG_A2_COEF:  a_ff[1]     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign req_tready = !busy_ff;
   assign accept     = req_tvalid && req_tready;
   assign hist_clear = accept && (req_tuser == dfi_pkg::OP_CLEAR);
   assign finish     = busy_ff && (step_ff == dfi_pkg::STEP_W'(dfi_pkg::STEP_LAST))
                       && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept && (req_tuser == dfi_pkg::OP_FILTER)) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (finish) begin
         busy_in = 1'b0;
      end else if (busy_ff && (step_ff != dfi_pkg::STEP_W'(dfi_pkg::STEP_LAST))) begin
         step_in = step_ff + 1'b1;
      end
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff <= req_tdata;
      end
      if (finish) begin
         rsp_data_ff <= y;
         rsp_sat_ff  <= sat;
      end
   end

   assign fb_tap = step_ff > dfi_pkg::STEP_W'(dfi_pkg::ORDER);
   assign a_full = step_ff - dfi_pkg::STEP_W'(dfi_pkg::ORDER + 1);

   always_comb begin
      coef = fb_tap ? a_ff[a_full[dfi_pkg::A_IDX_W-1:0]]
                    : b_ff[step_ff[dfi_pkg::B_IDX_W-1:0]];
      opnd = (step_ff == '0) ? x_ff : hist_rd;

      mac_ctrl.acc_clear = busy_ff && (step_ff == '0);
      mac_ctrl.mul_en    = busy_ff && (step_ff <= dfi_pkg::STEP_W'(2 * dfi_pkg::ORDER));
      mac_ctrl.neg       = fb_tap;
      mac_ctrl.zero      = fb_tap && fir_mode_ff;
      mac_ctrl.acc_en    = busy_ff && (step_ff != '0)
                           && (step_ff <= dfi_pkg::STEP_W'(2 * dfi_pkg::ORDER + 1));

      hist_wr.en   = 1'b0;
      hist_wr.addr = step_ff[dfi_pkg::HIST_AW-1:0];
      hist_wr.data = hist_rd;
      if (busy_ff && (step_ff == '0)) begin
         hist_wr.en   = 1'b1;
         hist_wr.addr = '0;
         hist_wr.data = x_ff;
      end else if (busy_ff && (step_ff != '0)
                   && (step_ff < dfi_pkg::STEP_W'(dfi_pkg::HIST_DEPTH))
                   && (step_ff != dfi_pkg::STEP_W'(dfi_pkg::ORDER))) begin
         hist_wr.en = 1'b1;
      end else if (finish) begin
         hist_wr.en   = 1'b1;
         hist_wr.addr = dfi_pkg::HIST_AW'(dfi_pkg::ORDER);
         hist_wr.data = y;
      end
   end

   dfi_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .clear   (hist_clear),
      .rd_addr (step_ff[dfi_pkg::HIST_AW-1:0]),
      .wr      (hist_wr),
      .rd_data (hist_rd)
   );

   dfi_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .coef  (coef),
      .opnd  (opnd),
      .y     (y),
      .sat   (sat)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (step_ff <= dfi_pkg::STEP_W'(dfi_pkg::STEP_LAST)))
      else $error("sequencer step out of range");

   assert property (@(posedge clock) disable iff (reset)
      !(hist_clear && hist_wr.en))
      else $error("history clear overlaps a history write");

   assert property (@(posedge clock) disable iff (reset)
      (accept && (req_tuser == dfi_pkg::OP_FILTER)) |=> (busy_ff && (step_ff == '0)))
      else $error("accepted sample did not start the sequencer");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(busy_ff && (step_ff == dfi_pkg::STEP_W'(dfi_pkg::STEP_LAST))))
      else $error("result appeared without a finished sample");

endmodule

>>> test/filter_output_checker.sv
module filter_output_checker
   import dfi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tready,
   input  logic [SMP_W-1:0]   req_tdata,  // [15:0] sample
   input  logic               req_tuser,  // [0] op
   input  logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic [SMP_W-1:0]   rsp_tdata,  // [15:0] filtered
   input  logic               rsp_tuser,  // [0] saturated
   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_addr,
   input  logic [CSR_DW-1:0]  csr_wdata,
   output int                 error_count,
   output int                 outputs_owed
);

   localparam longint Y_MAX = (longint'(1) <<< (SMP_W - 1)) - 1;
   localparam longint Y_MIN = -Y_MAX - 1;

   typedef struct packed {
      logic signed [SMP_W-1:0] filtered;
      logic                    saturated;
   } filter_output_type;

   logic                     fir_only;
   logic signed [COEF_W-1:0] b_coef [NUM_B];
   logic signed [COEF_W-1:0] a_coef [NUM_A];
   logic signed [SMP_W-1:0]  x_past [ORDER];
   logic signed [SMP_W-1:0]  y_past [ORDER];
   filter_output_type        pending_outputs [$];

   function automatic void clear_history();
      foreach (x_past[i]) begin
         x_past[i] = '0;
         y_past[i] = '0;
      end
   endfunction

   // Computes one output sample and shifts both histories.
   function automatic filter_output_type biquad_output(input logic signed [SMP_W-1:0] x);
      longint            acc;
      longint            y;
      int                k;
      filter_output_type res;
      acc = longint'(b_coef[0]) * longint'(x);
      for (k = 1; k <= ORDER; k++) begin
         acc += longint'(b_coef[k]) * longint'(x_past[k-1]);
         if (!fir_only)
            acc -= longint'(a_coef[k-1]) * longint'(y_past[k-1]);
      end
      y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      res.saturated = 1'b0;
      if (y > Y_MAX) begin
         y = Y_MAX;
         res.saturated = 1'b1;
      end
      if (y < Y_MIN) begin
         y = Y_MIN;
         res.saturated = 1'b1;
      end
      res.filtered = y[SMP_W-1:0];
      for (k = ORDER - 1; k > 0; k--) begin
         x_past[k] = x_past[k-1];
         y_past[k] = y_past[k-1];
      end
      x_past[0] = x;
      y_past[0] = res.filtered;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      filter_output_type want;
      if (reset) begin
         fir_only = 1'b0;
         b_coef[0] = B0_RESET;
         for (int i = 1; i < NUM_B; i++) b_coef[i] = '0;
         foreach (a_coef[i]) a_coef[i] = '0;
         clear_history();
         pending_outputs.delete();
         error_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               REG_FIR_MODE: fir_only = csr_wdata[0];
               REG_B0_COEF:  b_coef[0] = csr_wdata;
               REG_B1_COEF:  b_coef[1] = csr_wdata;
               REG_B2_COEF:  b_coef[2] = csr_wdata;
               REG_A1_COEF:  a_coef[0] = csr_wdata;
               REG_A2_COEF:  a_coef[1] = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_CLEAR)
               clear_history();
            else
               pending_outputs.push_back(biquad_output(req_tdata));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_outputs.size() == 0) begin
               $error("result transfer with no sample outstanding: filtered %0d",
                      $signed(rsp_tdata));
               error_count++;
            end else begin
               want = pending_outputs.pop_front();
               if (rsp_tdata !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d",
                         want.filtered, $signed(rsp_tdata));
                  error_count++;
               end
               if (rsp_tuser !== want.saturated) begin
                  $error("saturated: expected %0d, actual %0d", want.saturated, rsp_tuser);
                  error_count++;
               end
            end
         end
      end
      outputs_owed = pending_outputs.size();
   end

endmodule

>>> test/tb_iir_fir_direct_form_filter_core.sv
module tb_iir_fir_direct_form_filter_core;
   import dfi_pkg::*;

   localparam int LATENCY       = 2 * ORDER + 4;
   localparam int SETTLE_CYCLES = LATENCY + 8;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 150;
   localparam int HOLD_PHASE    = 2;

   localparam logic [CSR_AW-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [CSR_AW-1:0] REG_SPARE_HI = 3'd7;

   localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
   localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic [SMP_W-1:0]  SMP_MAX  = {1'b0, {(SMP_W-1){1'b1}}};
   localparam logic [SMP_W-1:0]  SMP_MIN  = {1'b1, {(SMP_W-1){1'b0}}};
   localparam logic [SMP_W-1:0]  SMP_ONE  = 16'd1;
   localparam logic [SMP_W-1:0]  SMP_NEG1 = 16'hFFFF;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [SMP_W-1:0]  req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [SMP_W-1:0]  rsp_tdata;
   logic              rsp_tuser;
   logic              csr_we;
   logic [CSR_AW-1:0] csr_addr;
   logic [CSR_DW-1:0] csr_wdata;

   int error_count;
   int outputs_owed;
   int cycle_count = 0;
   int req_gap_pct = 25;
   int rsp_stall_pct = 25;
   bit hold_request = 1'b0;

   always #2 clock = ~clock;

   iir_fir_direct_form_filter_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   filter_output_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .outputs_owed (outputs_owed)
   );

   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("iir_fir_direct_form_filter_core verification failed");
      $finish;
   end

   // The receiver stalls in short random bursts, and once for a long stretch on request.
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && $urandom_range(0, 99) < rsp_stall_pct) begin
            stall_left = $urandom_range(1, 6);
         end
         if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_item(input logic op, input logic [SMP_W-1:0] smp);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= smp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic sender_gap(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (outputs_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_AW-1:0] idx, input logic [CSR_DW-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [COEF_W-1:0] rand_coef(input int mag);
      int v;
      v = int'($urandom_range(0, 2 * mag)) - mag;
      return v[COEF_W-1:0];
   endfunction

   function automatic logic [SMP_W-1:0] random_sample();
      int v;
      case ($urandom_range(0, 9))
         0: return SMP_MAX;
         1: return SMP_MIN;
         2, 3, 4: begin
            v = int'($urandom_range(0, 600)) - 300;
            return v[SMP_W-1:0];
         end
         default: begin
            v = $urandom();
            return v[SMP_W-1:0];
         end
      endcase
   endfunction

   initial begin
      int   p;
      int   n;
      int   mag;
      logic op;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_FILTER;
      csr_we     = 1'b0;
      csr_addr   = REG_FIR_MODE;
      csr_wdata  = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset coefficients pass samples straight through.
      send_item(OP_FILTER, '0);
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, SMP_ONE);
      send_item(OP_FILTER, SMP_NEG1);
      send_item(OP_CLEAR, 16'hAAAA);
      send_item(OP_FILTER, 16'h5555);
      wait_drained();

      // Extreme coefficients drive the output into saturation in both directions.
      write_reg(REG_FIR_MODE, 24'hFFFFFE);
      write_reg(REG_B0_COEF, COEF_MAX);
      write_reg(REG_B1_COEF, COEF_MIN);
      write_reg(REG_B2_COEF, COEF_MAX);
      write_reg(REG_A1_COEF, COEF_MIN);
      write_reg(REG_A2_COEF, COEF_MAX);
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, '0);
      send_item(OP_CLEAR, SMP_MIN);
      send_item(OP_FILTER, SMP_NEG1);
      send_item(OP_FILTER, SMP_ONE);
      wait_drained();

      // FIR mode ignores the feedback taps but keeps the output history up to date.
      write_reg(REG_FIR_MODE, 24'hFFFFFF);
      write_reg(REG_B0_COEF, COEF_MIN);
      write_reg(REG_SPARE_LO, 24'hFFFFFF);
      write_reg(REG_SPARE_HI, 24'h5A5A5A);
      send_item(OP_FILTER, SMP_MIN);
      send_item(OP_FILTER, SMP_MAX);
      send_item(OP_FILTER, '0);
      wait_drained();
      write_reg(REG_FIR_MODE, 24'h000000);
      write_reg(REG_B0_COEF, 24'h100000);
      send_item(OP_FILTER, SMP_ONE);
      send_item(OP_FILTER, 16'h1234);
      send_item(OP_CLEAR, '0);

      for (p = 0; p < PHASES; p++) begin
         wait_drained();
         if (p == 1) begin
            write_reg(REG_FIR_MODE, 24'h000000);
            write_reg(REG_B0_COEF, COEF_MIN);
            write_reg(REG_B1_COEF, COEF_MAX);
            write_reg(REG_B2_COEF, COEF_MIN);
            write_reg(REG_A1_COEF, COEF_MAX);
            write_reg(REG_A2_COEF, COEF_MIN);
         end else begin
            mag = (p % 3 == 0) ? (1 << (COEF_W - 1)) - 1 : (1 << (FRAC_BITS - 1));
            write_reg(REG_FIR_MODE, CSR_DW'($urandom()));
            write_reg(REG_B0_COEF, rand_coef(mag));
            write_reg(REG_B1_COEF, rand_coef(mag));
            write_reg(REG_B2_COEF, rand_coef(mag));
            write_reg(REG_A1_COEF, rand_coef(mag));
            write_reg(REG_A2_COEF, rand_coef(mag));
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      CSR_DW'($urandom()));
         end
         req_gap_pct   = (p == 3 || p == PHASES - 1) ? 0 : 25;
         rsp_stall_pct = req_gap_pct;
         if (p == HOLD_PHASE)
            hold_request = 1'b1;
         for (n = 0; n < PHASE_ITEMS; n++) begin
            op = ($urandom_range(0, 11) == 0) ? OP_CLEAR : OP_FILTER;
            send_item(op, random_sample());
            if (p != HOLD_PHASE && $urandom_range(0, 99) < req_gap_pct)
               sender_gap($urandom_range(1, 6));
         end
      end
      wait_drained();

      if (error_count == 0 && outputs_owed == 0) begin
         $display("iir_fir_direct_form_filter_core verification clean");
      end else begin
         $display("iir_fir_direct_form_filter_core verification failed");
      end
      $finish;
   end

endmodule
